### hw/rtl/mtw_pkg.sv
package mtw_pkg;

  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int WORD_W        = 32;
  localparam int POS_W         = $clog2(STATE_WORDS);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Twist constants
  localparam word_t TOP_BIT  = 32'h8000_0000;
  localparam word_t LOW_BITS = 32'h7FFF_FFFF;
  localparam word_t TWIST_XOR = 32'h9908_B0DF;

  // Request commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

### hw/rtl/mtw_cell.sv
module mtw_cell
  import mtw_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  word_t     seed_word,
  input  word_t     shift_in,
  output word_t     word
);

  // Load a seed word, take the neighbor's word on a shift, otherwise hold
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= seed_word;
    end else if (ctl.shift) begin
      word <= shift_in;
    end
  end

endmodule

### hw/rtl/mtw_twist.sv
module mtw_twist
  import mtw_pkg::*;
(
  input  word_t head,
  input  word_t next_word,
  input  word_t mid_word,
  output word_t twisted
);

  word_t mixed;

  // Upper bit of the head word joined with the low bits of its neighbor
  assign mixed   = (head & TOP_BIT) | (next_word & LOW_BITS);
  assign twisted = mid_word ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : '0);

endmodule

### hw/rtl/mersenne_twist_word_generator.sv
// Channel   | handshake             | payload
// request   | req_valid / req_ready | cmd, seed_word
// word      | word_valid/word_ready | random_word
//
// A drawn word is in the word register in the next cycle; a new draw can be accepted
// every cycle while that register is empty or being taken. The state sits in a ring of
// 624 word cells that shifts one place per draw, so word i is always at cell 0.
// A load is taken without rotation when the ring is aligned (draw position 0);
// at draw position p > 0 it first rotates the ring back to 0, request held off.
// Reset clears the positions and the word valid; the cells are not cleared.
module mersenne_twist_word_generator
  import mtw_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  req_valid,
  output logic  req_ready,
  input  logic  cmd,
  input  word_t seed_word,
  output logic  word_valid,
  input  logic  word_ready,
  output word_t random_word
);

  pos_t      draw_pos;
  pos_t      load_pos;
  word_t     cells [STATE_WORDS];
  cell_ctl_t ctl   [STATE_WORDS];
  word_t     tail_in;
  word_t     twisted;
  logic      draw_ok;
  logic      rotate;
  logic      draw_acc;
  logic      load_acc;
  logic      shift;

  // Hold off a load until the ring is back at position 0
  assign draw_ok   = !word_valid || word_ready;
  assign req_ready = (cmd == CMD_DRAW) ? draw_ok : (draw_pos == '0);
  assign draw_acc  = req_valid && req_ready && (cmd == CMD_DRAW);
  assign load_acc  = req_valid && req_ready && (cmd == CMD_LOAD);
  assign rotate    = req_valid && (cmd == CMD_LOAD) && (draw_pos != '0);
  assign shift     = draw_acc || rotate;

  // Twist the three words at their fixed cells
  mtw_twist u_twist (
    .head      (cells[0]),
    .next_word (cells[1]),
    .mid_word  (cells[MIDDLE_OFFSET]),
    .twisted   (twisted)
  );

  // Tail takes the new word on a draw, the head word on a plain rotation
  assign tail_in = draw_acc ? twisted : cells[0];

  // Ring of cells
  for (genvar k = 0; k < STATE_WORDS; k++) begin : g_cell
    assign ctl[k].shift = shift;
    assign ctl[k].load  = load_acc && (load_pos == pos_t'(k));

    if (k == STATE_WORDS - 1) begin : g_tail
      mtw_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[k]),
        .seed_word (seed_word),
        .shift_in  (tail_in),
        .word      (cells[k])
      );
    end else begin : g_body
      mtw_cell u_cell (
        .clk       (clk),
        .ctl       (ctl[k]),
        .seed_word (seed_word),
        .shift_in  (cells[k+1]),
        .word      (cells[k])
      );
    end
  end

  // Advance positions and the word register
  always_ff @(posedge clk) begin
    if (rst) begin
      draw_pos   <= '0;
      load_pos   <= '0;
      word_valid <= 1'b0;
    end else begin
      if (shift) begin
        draw_pos <= (draw_pos == pos_t'(STATE_WORDS - 1)) ? '0 : draw_pos + 1'b1;
      end
      if (load_acc) begin
        load_pos <= (load_pos == pos_t'(STATE_WORDS - 1)) ? '0 : load_pos + 1'b1;
      end
      if (draw_acc) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (draw_acc) begin
      random_word <= twisted;
    end
  end

  // A load is only taken with the ring aligned
  assert property (@(posedge clk) disable iff (rst)
    load_acc |-> draw_pos == '0)
    else $error("load taken with ring not aligned");

  // A held load keeps the ring rotating toward position 0
  assert property (@(posedge clk) disable iff (rst)
    (rotate && draw_pos != pos_t'(STATE_WORDS - 1)) |=> draw_pos == $past(draw_pos) + 1'b1)
    else $error("ring did not rotate for a pending load");

  // Every accepted draw shows a word in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    draw_acc |=> word_valid && random_word == $past(twisted))
    else $error("draw result missing");

endmodule

### tb/tb_mersenne_twist_word_generator.sv
module tb_mersenne_twist_word_generator;
  import mtw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 850;
  localparam int DRAIN_CYCLES = 700;

  typedef struct packed {
    logic  op;
    word_t seed;
    logic  typed;
    word_t want;
  } dir_row_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  logic  cmd = CMD_LOAD;
  word_t seed_word = '0;
  logic  word_valid;
  logic  word_ready = 1'b0;
  word_t random_word;

  // Model copy of the generator state
  word_t twist_model [STATE_WORDS];
  int    model_draw_pos = 0;
  int    model_load_pos = 0;

  word_t pending_words[$];
  int    errors = 0;
  bit    quiet_stretch = 1'b0;
  int    stall_left = 0;

  // Words 0..7 and 397..404 are zero after the seed fill, so the rows marked
  // typed have results that follow by hand.
  dir_row_t directed_rows [25] = '{
    '{CMD_DRAW, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_DRAW, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
    '{CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b1, 32'h4000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_LOAD, 32'h0000_0001, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b1, TWIST_XOR},
    '{CMD_DRAW, 32'h0000_0000, 1'b1, 32'h0000_0000},
    '{CMD_LOAD, 32'h7FFF_FFFF, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_LOAD, 32'h8000_0000, 1'b0, 32'h0000_0000},
    '{CMD_LOAD, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_LOAD, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000},
    '{CMD_LOAD, 32'h5555_5555, 1'b0, 32'h0000_0000},
    '{CMD_LOAD, 32'hAAAA_AAAA, 1'b0, 32'h0000_0000},
    '{CMD_DRAW, 32'h0000_0000, 1'b0, 32'h0000_0000}
  };

  mersenne_twist_word_generator dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .cmd         (cmd),
    .seed_word   (seed_word),
    .word_valid  (word_valid),
    .word_ready  (word_ready),
    .random_word (random_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up after a generous bound
  initial begin
    #50_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic flag_mismatch(input string what, input word_t got, input word_t want);
    $display("ERROR at %0t: %s got %08h want %08h", $time, what, got, want);
    errors++;
  endtask

  // Mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_stretch || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Apply one request to the model state; report the drawn word if any
  task automatic advance_twist_model(input logic op, input word_t seed,
                                     output logic drew, output word_t word);
    int    cur;
    int    nxt;
    int    mid;
    word_t mixed;
    drew = 1'b0;
    word = '0;
    if (op == CMD_LOAD) begin
      twist_model[model_load_pos] = seed;
      model_load_pos = (model_load_pos + 1) % STATE_WORDS;
      model_draw_pos = 0;
    end else begin
      cur = model_draw_pos;
      nxt = (cur + 1) % STATE_WORDS;
      mid = (cur + MIDDLE_OFFSET) % STATE_WORDS;
      mixed = (twist_model[cur] & TOP_BIT) | (twist_model[nxt] & LOW_BITS);
      word = twist_model[mid] ^ (mixed >> 1) ^ (mixed[0] ? TWIST_XOR : '0);
      twist_model[cur] = word;
      model_draw_pos = nxt;
      drew = 1'b1;
    end
  endtask

  // Drive one request and hold it until taken; queue the word it yields
  task automatic send_request(input logic op, input word_t seed,
                              input logic typed, input word_t want);
    int    gap;
    logic  drew;
    word_t word;
    gap = idle_len();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd       <= op;
    seed_word <= seed;
    do @(posedge clk); while (!req_ready);
    advance_twist_model(op, seed, drew, word);
    if (drew) pending_words.push_back(typed ? want : word);
  endtask

  function automatic word_t random_seed();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Check words as they are taken and stall the word side at random
  always @(posedge clk) begin
    word_t want;
    if (!rst && word_valid && word_ready) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("word with none expected", random_word, '0);
      end else begin
        want = pending_words.pop_front();
        if (random_word !== want) flag_mismatch("random_word", random_word, want);
      end
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      word_ready <= 1'b0;
    end else begin
      word_ready <= 1'b1;
      if (!quiet_stretch && $urandom_range(0, 99) < 15) stall_left <= idle_len();
    end
  end

  initial begin
    int    sent;
    int    loads;
    int    draws;
    bit    first_run;
    for (int k = 0; k < STATE_WORDS; k++) twist_model[k] = '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Seed every word once; keep the words that the directed rows read at zero
    for (int k = 0; k < STATE_WORDS; k++) begin
      if (k < 8 || (k >= MIDDLE_OFFSET && k < MIDDLE_OFFSET + 8))
        send_request(CMD_LOAD, '0, 1'b0, '0);
      else
        send_request(CMD_LOAD, $urandom, 1'b0, '0);
    end

    // Walk the directed rows
    foreach (directed_rows[r])
      send_request(directed_rows[r].op, directed_rows[r].seed,
                   directed_rows[r].typed, directed_rows[r].want);

    // Random bursts of loads followed by runs of draws; the first run wraps
    // the draw position exactly once, and a rare long run may wrap it again
    sent = 0;
    first_run = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      quiet_stretch = ($urandom_range(0, 4) == 0);
      loads = first_run ? 0 : $urandom_range(0, 3);
      for (int k = 0; k < loads; k++) send_request(CMD_LOAD, random_seed(), 1'b0, '0);
      if (first_run)
        draws = STATE_WORDS;
      else if ($urandom_range(0, 19) == 0)
        draws = $urandom_range(STATE_WORDS + 1, STATE_WORDS + 80);
      else
        draws = $urandom_range(1, 40);
      for (int k = 0; k < draws; k++) send_request(CMD_DRAW, $urandom, 1'b0, '0);
      sent += loads + draws;
      first_run = 1'b0;
    end
    quiet_stretch = 1'b0;

    // Drop the request and drain
    req_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
